[rtl/assert_macros.svh]
// ------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker modules.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never hold at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_CLK(label, clk, rst_n, !(expr))

`endif

[rtl/bpt_pkg.sv]
// ------------------------------------------------------------------------
// bpt_pkg
// Shared constants, types and helpers of the bit-plane transposer.
// ------------------------------------------------------------------------
package bpt_pkg;

    localparam int CHUNK_ELEMENTS = 64;
    localparam int MAX_PLANES     = 16;
    localparam int VALUE_W        = 16;
    localparam int PLANE_W        = CHUNK_ELEMENTS;
    localparam int POS_W          = $clog2(CHUNK_ELEMENTS);
    localparam int PLANE_IDX_W    = $clog2(MAX_PLANES);
    localparam int PLANE_CNT_W    = $clog2(MAX_PLANES + 1);
    localparam int CFG_W          = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef logic [MAX_PLANES-1:0][PLANE_W-1:0] t_planes;

    // Chunk handoff from the collector to the emitter
    typedef struct packed {
        logic                   load;
        logic [PLANE_CNT_W-1:0] nplanes;
    } t_handoff;

    // Clamp the register to the range of planes actually given out
    function automatic logic [PLANE_CNT_W-1:0] clamp_planes(input logic [CFG_W-1:0] b);
        logic [PLANE_CNT_W-1:0] r;
        if (b == '0) begin
            r = PLANE_CNT_W'(1);
        end else if (32'(b) > MAX_PLANES) begin
            r = PLANE_CNT_W'(MAX_PLANES);
        end else begin
            r = PLANE_CNT_W'(b);
        end
        return r;
    endfunction

endpackage

[rtl/bit_plane_transpose_64.sv]
// ------------------------------------------------------------------------
// bit_plane_transpose_64
// Transposes chunks of 64 unsigned values into bit-plane words.
//
//   channel   dir  fields (low bit up)                  handshake
//   s_axis    in   tdata: element_value[15:0]           tvalid/tready
//   m_axis    out  tdata: plane_word[63:0]              tvalid/tready
//                  tuser: plane_index[3:0], tlast: last_plane
//   cfg       in   bits_per_value[4:0]                  i_cfg_wr_en
//
// One element is taken per cycle. The 64th element of a chunk hands the
// finished planes to a separate output buffer, which gives up to 16 plane
// words, one per cycle while m_axis_tready is high, while the next chunk is built.
// The input stalls only on a chunk's last element while the output buffer
// still holds words of the previous chunk.
// Reset clears the planes, the position and the output buffer's word count;
// the register returns to 16.
// ------------------------------------------------------------------------
module bit_plane_transpose_64 import bpt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_W-1:0]     s_axis_tdata,   // element_value[15:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [PLANE_W-1:0]     m_axis_tdata,   // plane_word[63:0]
    output logic [PLANE_IDX_W-1:0] m_axis_tuser,   // plane_index[3:0]
    output logic                   m_axis_tlast
);

    logic     in_accept;
    logic     at_last;
    logic     busy;
    t_handoff handoff;
    t_planes  planes;

    // Hold the last element of a chunk until the output buffer is free
    assign s_axis_tready = !(at_last && busy);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = busy;

    bpt_collect u_collect (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_value       (s_axis_tdata),
        .o_at_last     (at_last),
        .o_handoff     (handoff),
        .o_planes      (planes)
    );

    bpt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_handoff   (handoff),
        .i_planes    (planes),
        .i_out_ready (m_axis_tready),
        .o_busy      (busy),
        .o_word      (m_axis_tdata),
        .o_index     (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

[rtl/bpt_collect.sv]
// ------------------------------------------------------------------------
// bpt_collect
// Builds the bit-plane words of the current chunk, one element per item,
// and hands the finished chunk to the emitter on its last element.
// ------------------------------------------------------------------------
module bpt_collect import bpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    input  logic               i_accept,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_at_last,
    output t_handoff           o_handoff,
    output t_planes            o_planes
);

    logic [CFG_W-1:0]   r_bits;
    logic [POS_W-1:0]   r_count;
    t_planes            r_planes;
    t_planes            n_planes;
    logic [PLANE_W-1:0] pos_mask;
    logic               done;

    // Merge the element's bits into every plane at its chunk position
    always_comb begin
        pos_mask = PLANE_W'(1) << (POS_W'(CHUNK_ELEMENTS - 1) - r_count);
        for (int k = 0; k < MAX_PLANES; k++) begin
            n_planes[k] = r_planes[k] | (i_value[k] ? pos_mask : '0);
        end
    end

    assign o_at_last         = (r_count == POS_W'(CHUNK_ELEMENTS - 1));
    assign done              = i_accept && o_at_last;
    assign o_handoff.load    = done;
    assign o_handoff.nplanes = clamp_planes(r_bits);
    assign o_planes          = n_planes;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_bits <= i_cfg_wr_data;
        end
    end

    // Advance position, clear planes at end of chunk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_planes <= '0;
        end else if (i_accept) begin
            r_count <= POS_W'(r_count + 1'b1);
            if (done) begin
                r_planes <= '0;
            end else begin
                r_planes <= n_planes;
            end
        end
    end

endmodule

[rtl/bpt_emit.sv]
// ------------------------------------------------------------------------
// bpt_emit
// Holds a finished chunk and shifts its plane words out, lowest plane
// first, marking the last one.
// ------------------------------------------------------------------------
module bpt_emit import bpt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_handoff               i_handoff,
    input  t_planes                i_planes,
    input  logic                   i_out_ready,
    output logic                   o_busy,
    output logic [PLANE_W-1:0]     o_word,
    output logic [PLANE_IDX_W-1:0] o_index,
    output logic                   o_last
);

    t_planes                r_buf;
    t_planes                n_buf;
    logic [PLANE_CNT_W-1:0] r_left;
    logic [PLANE_CNT_W-1:0] n_left;
    logic [PLANE_IDX_W-1:0] r_idx;
    logic [PLANE_IDX_W-1:0] n_idx;
    logic                   out_accept;

    assign o_busy     = (r_left != '0);
    assign out_accept = o_busy && i_out_ready;
    assign o_word     = r_buf[0];
    assign o_index    = r_idx;
    assign o_last     = (r_left == PLANE_CNT_W'(1));

    // Load a new chunk or shift one word out
    always_comb begin
        n_buf  = r_buf;
        n_left = r_left;
        n_idx  = r_idx;
        if (i_handoff.load) begin
            n_buf  = i_planes;
            n_left = i_handoff.nplanes;
            n_idx  = '0;
        end else if (out_accept) begin
            for (int k = 0; k < MAX_PLANES - 1; k++) begin
                n_buf[k] = r_buf[k + 1];
            end
            n_left = PLANE_CNT_W'(r_left - 1'b1);
            n_idx  = PLANE_IDX_W'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else begin
            r_left <= n_left;
            r_idx  <= n_idx;
        end
    end

    // Word buffer holds payload only
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

endmodule

[rtl/bpt_checker.sv]
// ------------------------------------------------------------------------
// bpt_checker
// Port-level checks on the plane word stream of the transposer.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module bpt_checker import bpt_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [PLANE_IDX_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    logic                   out_acc;
    logic                   in_run;
    logic [PLANE_IDX_W-1:0] idx_next;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign in_run   = out_acc && !m_axis_tlast;
    assign idx_next = PLANE_IDX_W'(m_axis_tuser + 1'b1);

    // Valid is not withdrawn while the item waits
    `ASSERT_CLK(a_valid_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    // A chunk's words follow without a gap in the run
    `ASSERT_CLK(a_run_cont, i_clk, i_rst_n, in_run |=> m_axis_tvalid && (m_axis_tuser == $past(idx_next)))
    // In the cycle after the marked word the buffer is empty
    `ASSERT_CLK(a_last_drain, i_clk, i_rst_n, out_acc && m_axis_tlast |=> !m_axis_tvalid)
    // Every run starts at plane zero
    `ASSERT_NEVER(a_run_start, i_clk, i_rst_n, $rose(m_axis_tvalid) && (m_axis_tuser != '0))
    // The input is held off only while plane words are still waiting
    `ASSERT_NEVER(a_in_stall, i_clk, i_rst_n, s_axis_tvalid && !s_axis_tready && !m_axis_tvalid)

endmodule

bind bit_plane_transpose_64 bpt_checker u_bpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[bench/plane_check_pkg.sv]
// ----------------------------------------------------------------------------
// plane_check_pkg
// Tracks the plane words that the transposer owes and checks the ones that
// it gives out, in order, field by field.
// ----------------------------------------------------------------------------
package plane_check_pkg;

    import bpt_pkg::*;

    // One plane word as it leaves the block
    typedef struct packed {
        logic [PLANE_W-1:0]     word;
        logic [PLANE_IDX_W-1:0] index;
        logic                   is_last;
    } t_plane_item;

    class plane_scoreboard;

        logic [PLANE_W-1:0] planes [MAX_PLANES];
        logic [POS_W-1:0]   position;
        logic [CFG_W-1:0]   bits_per_value;
        t_plane_item        due_planes [$];
        int                 mismatches;

        function new();
            foreach (planes[k]) planes[k] = '0;
            position       = '0;
            bits_per_value = CFG_RESET;
            mismatches     = 0;
        endfunction

        function void set_bits(input logic [CFG_W-1:0] value);
            bits_per_value = value;
        endfunction

        // Zero acts as one plane, anything past the plane count as all planes
        function int unsigned planes_out();
            if (bits_per_value == '0) begin
                return 1;
            end
            if (int'(bits_per_value) > MAX_PLANES) begin
                return MAX_PLANES;
            end
            return int'(bits_per_value);
        endfunction

        // Fold one element into every plane; on the chunk's last element queue
        // the words in plane order and start a fresh chunk
        function void note_element(input logic [VALUE_W-1:0] value);
            int unsigned count;
            t_plane_item item;
            for (int k = 0; k < MAX_PLANES; k++) begin
                if (value[k]) begin
                    planes[k][PLANE_W-1-position] = 1'b1;
                end
            end
            if (position != POS_W'(CHUNK_ELEMENTS - 1)) begin
                position++;
                return;
            end
            count = planes_out();
            for (int unsigned k = 0; k < count; k++) begin
                item.word    = planes[k];
                item.index   = PLANE_IDX_W'(k);
                item.is_last = (k == count - 1);
                due_planes.push_back(item);
            end
            foreach (planes[k]) planes[k] = '0;
            position = '0;
        endfunction

        function int pending();
            return due_planes.size();
        endfunction

        task report(input string what);
            mismatches++;
            $display("[%0t] plane check failed: %s", $time, what);
        endtask

        // Compare one accepted plane word with the oldest one owed
        task check_plane(input logic [PLANE_W-1:0] word,
                         input logic [PLANE_IDX_W-1:0] index,
                         input logic is_last);
            t_plane_item want;
            if (due_planes.size() == 0) begin
                report($sformatf("unexpected word %h index %0d", word, index));
                return;
            end
            want = due_planes.pop_front();
            if (word !== want.word) begin
                report($sformatf("plane %0d word %h, want %h", want.index, word, want.word));
            end
            if (index !== want.index) begin
                report($sformatf("plane index %0d, want %0d", index, want.index));
            end
            if (is_last !== want.is_last) begin
                report($sformatf("plane %0d last flag %b, want %b",
                                 want.index, is_last, want.is_last));
            end
        endtask

    endclass

endpackage

[bench/bit_plane_transpose_64_test.sv]
// ----------------------------------------------------------------------------
// bit_plane_transpose_64_test
// Streams element values through the transposer under several plane counts,
// with random gaps on both sides and one long output stall, and checks every
// plane word against a local model of the chunk planes.
// ----------------------------------------------------------------------------
module bit_plane_transpose_64_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bpt_pkg::*;
    import plane_check_pkg::*;

    localparam int MAX_GAP       = 19;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int IDLE_LIMIT    = 2000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_W-1:0]       i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [VALUE_W-1:0]     s_axis_tdata;   // element_value[15:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [PLANE_W-1:0]     m_axis_tdata;   // plane_word[63:0]
    logic [PLANE_IDX_W-1:0] m_axis_tuser;   // plane_index[3:0]
    logic                   m_axis_tlast;

    plane_scoreboard ledger;
    bit              hold_request = 1'b0;
    bit              sender_dense = 1'b0;
    bit              rx_dense     = 1'b0;
    int              idle_cycles  = 0;

    bit_plane_transpose_64 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one item after a drawn gap and hold it until taken
    task automatic send_element(input logic [VALUE_W-1:0] value);
        int gap;
        gap = sender_dense ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ledger.note_element(value);
    endtask

    task automatic write_register(input logic [CFG_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ledger.set_bits(value);
    endtask

    // Stop offering, wait for every owed word, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly values within the plane count, some with stray high bits
    function automatic logic [VALUE_W-1:0] pick_element(input int unsigned planes);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
            return VALUE_W'($urandom) & VALUE_W'((32'h1 << planes) - 1);
        end
        if (roll < 8) begin
            return VALUE_W'($urandom);
        end
        if (roll == 8) begin
            return '0;
        end
        return {VALUE_W{1'b1}};
    endfunction

    task automatic run_phase(input int unsigned count);
        sender_dense = ($urandom_range(0, 3) == 0);
        repeat (count) send_element(pick_element(ledger.planes_out()));
        drain();
    endtask

    // Result side: random stalls, dense stretches and one long hold-off
    initial begin
        int          gap;
        int unsigned taken;
        m_axis_tready <= 1'b0;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 24 == 0) begin
                rx_dense = ($urandom_range(0, 3) == 0);
            end
            gap = rx_dense ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) begin
                if (hold_request) begin
                    hold_request = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
                @(posedge i_clk);
            end
            ledger.check_plane(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            taken++;
        end
    end

    // Abort when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        ledger = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening chunk at the reset width: all ones, all zeros, walking ones, alternating bits, random fill
        send_element({VALUE_W{1'b1}});
        send_element('0);
        for (int k = 0; k < VALUE_W; k++) begin
            send_element(VALUE_W'(1) << k);
        end
        send_element(VALUE_W'(16'hAAAA));
        send_element(VALUE_W'(16'h5555));
        repeat (CHUNK_ELEMENTS - VALUE_W - 4) send_element(VALUE_W'($urandom));
        drain();

        // Narrowest width, then zero and out-of-range values; phases may end mid-chunk
        write_register(CFG_W'(1));
        run_phase($urandom_range(12, 36));
        write_register(CFG_W'(0));
        run_phase($urandom_range(12, 36));
        write_register(CFG_W'(31));
        run_phase($urandom_range(12, 36));
        write_register(CFG_W'(17));
        run_phase($urandom_range(12, 36));

        // Full width with back-to-back items while the output holds off
        write_register(CFG_W'(16));
        hold_request = 1'b1;
        sender_dense = 1'b1;
        repeat (150) send_element(pick_element(ledger.planes_out()));
        drain();

        repeat (4) begin
            write_register(CFG_W'($urandom_range(1, MAX_PLANES)));
            run_phase($urandom_range(12, 36));
        end

        if (ledger.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
